FILE: src/vcsl_pkg.sv
// ----------------------------------------------------------------------------
// vcsl_pkg: shared definitions for the voxel corner smooth light core
// Field widths, scale constants, payload structs and small helper functions.
// ----------------------------------------------------------------------------
package vcsl_pkg;

    localparam int unsigned NCELL   = 8;
    localparam int unsigned LIGHT_W = 8;
    localparam int unsigned START_W = 3;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned SUM_W   = 11;
    localparam int unsigned SCALE_W = 11;
    localparam int unsigned NUM_W   = SUM_W + SCALE_W;
    localparam int unsigned FACT_W  = 6;
    localparam int unsigned DEN_W   = LIGHT_W + FACT_W;
    localparam int unsigned QUOT_W  = 8;

    localparam int unsigned IN_W    = 80;
    localparam int unsigned OUT_W   = 24;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [0:0] REG_FULL_SCALE = 1'b0;
    localparam logic [LIGHT_W-1:0] FULL_SCALE_RESET = 8'd15;

    localparam logic [SCALE_W-1:0] SCALE_PART = 11'd2040;
    localparam logic [SCALE_W-1:0] SCALE_FULL = 11'd255;
    localparam logic [CNT_W-1:0]   CNT_FULL   = 4'd8;

    typedef logic [NCELL-1:0][LIGHT_W-1:0] light_arr_t;

    typedef struct packed {
        logic [NCELL-1:0] reach_mask;
        logic [CNT_W-1:0] reach_count;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        side_t            side;
    } div_req_t;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        side_t             side;
    } div_rsp_t;

    typedef struct packed {
        logic             bit_set;
        logic [NUM_W-1:0] rem;
    } div_step_t;

    // One flood-fill step: open cells next to a reached cell along one axis join.
    function automatic logic [NCELL-1:0] reach_grow(input logic [NCELL-1:0] reach,
                                                    input logic [NCELL-1:0] open);
        logic [NCELL-1:0] nb;
        for (int c = 0; c < NCELL; c++)
        begin
            nb[c] = reach[c ^ 1] | reach[c ^ 2] | reach[c ^ 4];
        end
        return reach | (open & nb);
    endfunction

    // Denominator factor: 7*(n+1) for a partial set, 8 for a full set.
    function automatic logic [FACT_W-1:0] den_factor(input logic [CNT_W-1:0] n);
        logic [FACT_W-1:0] f;
        case (n)
            4'd0:    f = 6'd7;
            4'd1:    f = 6'd14;
            4'd2:    f = 6'd21;
            4'd3:    f = 6'd28;
            4'd4:    f = 6'd35;
            4'd5:    f = 6'd42;
            4'd6:    f = 6'd49;
            4'd7:    f = 6'd56;
            default: f = 6'd8;
        endcase
        return f;
    endfunction

    // One restoring division step for quotient bit k.
    function automatic div_step_t div_step(input logic [NUM_W-1:0] rem,
                                           input logic [DEN_W-1:0] den,
                                           input int unsigned k);
        logic [NUM_W:0] sh;
        div_step_t      r;
        sh = {{(NUM_W+1-DEN_W){1'b0}}, den} << k;
        if ({1'b0, rem} >= sh)
        begin
            r.bit_set = 1'b1;
            r.rem     = rem - sh[NUM_W-1:0];
        end
        else
        begin
            r.bit_set = 1'b0;
            r.rem     = rem;
        end
        return r;
    endfunction

endpackage

FILE: src/vcsl_div.sv
// ----------------------------------------------------------------------------
// vcsl_div: pipelined restoring divider with saturation
// One saturation stage, then four stages of two quotient bits each.
// ----------------------------------------------------------------------------
module vcsl_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_vld,
    input  vcsl_pkg::div_req_t req,
    output logic              out_vld,
    output vcsl_pkg::div_rsp_t rsp
);

    localparam int unsigned NST = 5;

    logic [NST-1:0]                vld_reg;
    logic [NST-1:0]                vld_next;
    logic [vcsl_pkg::NUM_W-1:0]    rem_reg  [NST];
    logic [vcsl_pkg::DEN_W-1:0]    den_reg  [NST];
    logic [vcsl_pkg::QUOT_W-1:0]   quot_reg [NST];
    logic                          sat_reg  [NST];
    vcsl_pkg::side_t               side_reg [NST];

    assign vld_next = adv ? {vld_reg[NST-2:0], in_vld} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= req.num;
            den_reg[0]  <= req.den;
            quot_reg[0] <= '0;
            sat_reg[0]  <= ({1'b0, req.num} >= {1'b0, req.den, 8'b0});
            side_reg[0] <= req.side;
        end
    end

    for (genvar j = 1; j < NST; j++)
    begin : g_step
        localparam int unsigned KH = 9 - 2 * j;
        localparam int unsigned KL = KH - 1;

        vcsl_pkg::div_step_t st_hi;
        vcsl_pkg::div_step_t st_lo;
        logic [vcsl_pkg::QUOT_W-1:0] q_next;

        assign st_hi = vcsl_pkg::div_step(rem_reg[j-1], den_reg[j-1], KH);
        assign st_lo = vcsl_pkg::div_step(st_hi.rem, den_reg[j-1], KL);

        always_comb
        begin
            q_next     = quot_reg[j-1];
            q_next[KH] = st_hi.bit_set;
            q_next[KL] = st_lo.bit_set;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= st_lo.rem;
                den_reg[j]  <= den_reg[j-1];
                quot_reg[j] <= q_next;
                sat_reg[j]  <= sat_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_vld   = vld_reg[NST-1];
    assign rsp.quot  = sat_reg[NST-1] ? {vcsl_pkg::QUOT_W{1'b1}} : quot_reg[NST-1];
    assign rsp.side  = side_reg[NST-1];

endmodule

FILE: src/voxel_corner_smooth_light_core.sv
// ----------------------------------------------------------------------------
// voxel_corner_smooth_light_core: smoothed light level at one voxel vertex
// Flood fill over a 2x2x2 corner, light sum and normalised division.
// ----------------------------------------------------------------------------
// Each input transfer carries one corner: the start cell, the transparency
// mask and eight light levels of one channel. Each output transfer carries
// the normalised vertex light, the mask of reached cells and their count.
// Items are independent, so one transfer is accepted in every cycle unless
// the receiver stalls the output. An input transfer passes through four
// stages for the flood fill, count, sum and products, then five divider
// stages, before its result is offered as an output transfer.
// The divider's comparators and the two multipliers of stage 4 set the depth.
// The pipeline advances as a whole; when the receiver stalls a valid
// result, every stage holds and s_tready falls in the same cycle.
// Reset empties the pipeline and sets the full-scale register to 15. The
// APB full-scale register (byte address 0) must be written only while the
// core is idle.
// ----------------------------------------------------------------------------
module voxel_corner_smooth_light_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_corner[2:0], open_mask[10:3], light_c0..light_c7[74:11], zeros
    input  logic [vcsl_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // vertex_light[7:0], reach_mask[15:8], reach_count[19:16], zeros
    output logic [vcsl_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vcsl_pkg::ADDR_W-1:0]   paddr,
    input  logic [vcsl_pkg::DATA_W-1:0]   pwdata,
    output logic [vcsl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic                               adv;
    logic [vcsl_pkg::LIGHT_W-1:0]       full_scale_reg;
    logic [vcsl_pkg::LIGHT_W-1:0]       full_scale_next;
    logic [vcsl_pkg::LIGHT_W-1:0]       ml_eff;

    logic [vcsl_pkg::START_W-1:0]       in_start;
    logic [vcsl_pkg::NCELL-1:0]         in_open;
    vcsl_pkg::light_arr_t               in_light;
    logic [vcsl_pkg::NCELL-1:0]         s1_reach;

    logic [3:0]                         vld_reg;
    logic [3:0]                         vld_next;
    logic [vcsl_pkg::NCELL-1:0]         s1_reach_reg;
    logic [vcsl_pkg::NCELL-1:0]         s1_open_reg;
    vcsl_pkg::light_arr_t               s1_light_reg;
    logic [vcsl_pkg::NCELL-1:0]         s2_reach;
    logic [vcsl_pkg::NCELL-1:0]         s2_reach_reg;
    vcsl_pkg::light_arr_t               s2_light_reg;
    logic [vcsl_pkg::SUM_W-1:0]         s3_sum;
    logic [vcsl_pkg::CNT_W-1:0]         s3_cnt;
    logic [vcsl_pkg::SUM_W-1:0]         s3_sum_reg;
    logic [vcsl_pkg::CNT_W-1:0]         s3_cnt_reg;
    logic [vcsl_pkg::NCELL-1:0]         s3_reach_reg;
    logic [vcsl_pkg::SCALE_W-1:0]       s4_scale;
    vcsl_pkg::div_req_t                 s4_req;
    vcsl_pkg::div_req_t                 s4_req_reg;

    logic                               div_vld;
    vcsl_pkg::div_rsp_t                 div_rsp;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == vcsl_pkg::REG_FULL_SCALE)
                  ? {{(vcsl_pkg::DATA_W-vcsl_pkg::LIGHT_W){1'b0}}, full_scale_reg}
                  : '0;

    always_comb
    begin
        full_scale_next = full_scale_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == vcsl_pkg::REG_FULL_SCALE))
        begin
            full_scale_next = pwdata[vcsl_pkg::LIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= vcsl_pkg::FULL_SCALE_RESET;
        end
        else
        begin
            full_scale_reg <= full_scale_next;
        end
    end

    assign ml_eff = (full_scale_reg == '0) ? 8'd1 : full_scale_reg;

    // Pipeline control: every stage moves together unless the output is held.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign vld_next = adv ? {vld_reg[2:0], s_tvalid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: seed and first four flood-fill steps.
    assign in_start = s_tdata[2:0];
    assign in_open  = s_tdata[10:3];
    assign in_light = s_tdata[74:11];

    always_comb
    begin
        s1_reach = in_open[in_start] ? (8'b1 << in_start) : 8'b0;
        for (int i = 0; i < 4; i++)
        begin
            s1_reach = vcsl_pkg::reach_grow(s1_reach, in_open);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reach_reg <= s1_reach;
            s1_open_reg  <= in_open;
            s1_light_reg <= in_light;
        end
    end

    // Stage 2: the remaining three flood-fill steps.
    always_comb
    begin
        s2_reach = s1_reach_reg;
        for (int i = 0; i < 3; i++)
        begin
            s2_reach = vcsl_pkg::reach_grow(s2_reach, s1_open_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reach_reg <= s2_reach;
            s2_light_reg <= s1_light_reg;
        end
    end

    // Stage 3: count the reached cells and sum their light.
    always_comb
    begin
        s3_sum = '0;
        s3_cnt = '0;
        for (int c = 0; c < vcsl_pkg::NCELL; c++)
        begin
            if (s2_reach_reg[c])
            begin
                s3_sum = s3_sum + {3'b0, s2_light_reg[c]};
                s3_cnt = s3_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_sum_reg   <= s3_sum;
            s3_cnt_reg   <= s3_cnt;
            s3_reach_reg <= s2_reach_reg;
        end
    end

    // Stage 4: numerator and denominator products.
    assign s4_scale = (s3_cnt_reg == vcsl_pkg::CNT_FULL) ? vcsl_pkg::SCALE_FULL
                                                         : vcsl_pkg::SCALE_PART;
    assign s4_req.num = s3_sum_reg * s4_scale;
    assign s4_req.den = ml_eff * vcsl_pkg::den_factor(s3_cnt_reg);
    assign s4_req.side.reach_mask  = s3_reach_reg;
    assign s4_req.side.reach_count = s3_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_req_reg <= s4_req;
        end
    end

    vcsl_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (vld_reg[3]),
        .req     (s4_req_reg),
        .out_vld (div_vld),
        .rsp     (div_rsp)
    );

    assign m_tvalid = div_vld;
    assign m_tdata  = {4'b0, div_rsp.side.reach_count, div_rsp.side.reach_mask,
                       div_rsp.quot};

`ifndef SYNTHESIS
    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones(m_tdata[15:8]) == int'(m_tdata[19:16])))
        else $error("reach_count does not match reach_mask");

    a_empty_reach_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[15:8] == 8'd0)) |-> (m_tdata[7:0] == 8'd0))
        else $error("light reported with no reached cell");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule
